### hw/rtl/cbm_pkg.sv
// ---------------------------------------------------------------------------
// cbm_pkg
// Shared types, constants and helpers for the cartridge bank mapper.
// ---------------------------------------------------------------------------
package cbm_pkg;

   // storage widths of the bank slots
   localparam int ROM_BANK_BITS  = 8;
   localparam int VROM_BANK_BITS = 10;

   // table geometry
   localparam int CPU_SLOTS     = 5;
   localparam int VID_SLOTS     = 12;
   localparam int CPU_IDX_BITS  = $clog2(CPU_SLOTS);
   localparam int VID_IDX_BITS  = $clog2(VID_SLOTS);
   localparam int CPU_FIRST_PG  = 3;
   localparam int CPU_LAST_PG   = CPU_FIRST_PG + CPU_SLOTS - 1;
   localparam int PATT_SLOTS    = 8;

   // field widths
   localparam int TYPE_W   = 3;
   localparam int SLOT_W   = 4;
   localparam int BANK_W   = 16;
   localparam int ADDR_W   = 16;
   localparam int PHYS_W   = 21;
   localparam int ROM_CNT_W  = 9;
   localparam int VROM_CNT_W = 11;
   localparam int CSR_DATA_W = 11;
   localparam int CSR_IDX_W  = 1;

   // page geometry
   localparam int CPU_OFS_BITS = 13;
   localparam int VID_OFS_BITS = 10;

   // reset values of the bank counts
   localparam logic [ROM_CNT_W-1:0]  ROM_CNT_RST  = ROM_CNT_W'(2);
   localparam logic [VROM_CNT_W-1:0] VROM_CNT_RST = VROM_CNT_W'(8);

   // RAM page masks and the last mapped video address
   localparam logic [BANK_W-1:0] PATT_PAGE_MASK = 16'h000F;
   localparam logic [BANK_W-1:0] NAMT_PAGE_MASK = 16'h0003;
   localparam logic [ADDR_W-1:0] VID_ADDR_LAST  = 16'h2FFF;

   typedef enum logic [TYPE_W-1:0] {
      REQ_SET_ROM  = 3'd0,
      REQ_SET_VROM = 3'd1,
      REQ_SET_VRAM = 3'd2,
      REQ_XLAT_CPU = 3'd3,
      REQ_XLAT_VID = 3'd4
   } req_kind_type;

   typedef enum logic [1:0] {
      SPACE_PROG = 2'd0,
      SPACE_VROM = 2'd1,
      SPACE_PATT = 2'd2,
      SPACE_NAMT = 2'd3
   } space_type;

   typedef struct packed {
      space_type                 src;
      logic [VROM_BANK_BITS-1:0] bank;
   } vid_entry_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROM_COUNT  = 1'd0,
      CSR_VROM_COUNT = 1'd1
   } csr_index_type;

   // smallest all-ones value covering m
   function automatic logic [BANK_W-1:0] cover_mask(input logic [BANK_W-1:0] m);
      logic [BANK_W-1:0] r;
      r = m;
      r = r | (r >> 1);
      r = r | (r >> 2);
      r = r | (r >> 4);
      r = r | (r >> 8);
      return r;
   endfunction

endpackage

### hw/rtl/cartridge_bank_mapper.sv
// ---------------------------------------------------------------------------
// cartridge_bank_mapper
// Bank switching table: five 8K program slots and twelve 1K video slots,
// written one slot at a time, and address translation through the table.
//   Response valid rises in the cycle after the request transfer.
//   Throughput: one item per cycle; the single response register stalls
//   the request side only while it holds an untaken response.
//   Reset (sync, active high): all slots bank 0 (video source video ROM),
//   ROM count 2, video ROM count 8, response register empty.
// ---------------------------------------------------------------------------
module cartridge_bank_mapper (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [cbm_pkg::TYPE_W-1:0]       req_type,
   input  logic [cbm_pkg::SLOT_W-1:0]       req_slot,
   input  logic [cbm_pkg::BANK_W-1:0]       req_bank_num,
   input  logic [cbm_pkg::ADDR_W-1:0]       req_address,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_accepted,
   output logic [1:0]                       rsp_target_space,
   output logic [cbm_pkg::PHYS_W-1:0]       rsp_phys_addr,
   // configuration
   input  logic                             csr_we,
   input  logic [cbm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cbm_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // ---------------------------------------------------------------
   // State
   // ---------------------------------------------------------------
   logic [cbm_pkg::ROM_CNT_W-1:0]     rom_cnt_ff;
   logic [cbm_pkg::VROM_CNT_W-1:0]    vrom_cnt_ff;
   logic [cbm_pkg::ROM_BANK_BITS-1:0] cpu_bank_ff [cbm_pkg::CPU_SLOTS];
   cbm_pkg::vid_entry_type            vid_entry_ff [cbm_pkg::VID_SLOTS];

   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_acc_ff, rsp_acc_in;
   cbm_pkg::space_type                rsp_space_ff, rsp_space_in;
   logic [cbm_pkg::PHYS_W-1:0]        rsp_phys_ff, rsp_phys_in;

   // ---------------------------------------------------------------
   // Handshake: response register frees up in the cycle it is taken
   // ---------------------------------------------------------------
   logic xfer;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign xfer      = req_valid && req_ready;

   // ---------------------------------------------------------------
   // Bank checks. Mask covers count-1; a zero count gives all ones,
   // so nothing is ever below it and every checked write is rejected.
   // ---------------------------------------------------------------
   logic [cbm_pkg::BANK_W-1:0] rom_cover, rom_b, vrom_cover, vrom_b;
   logic                       rom_ok, vrom_ok;

   assign rom_cover = cbm_pkg::cover_mask(cbm_pkg::BANK_W'(rom_cnt_ff) - 16'd1);
   assign rom_b     = req_bank_num & rom_cover;
   // also reject banks that would not fit the slot storage
   assign rom_ok    = (rom_b < cbm_pkg::BANK_W'(rom_cnt_ff)) &&
                      ((rom_b >> cbm_pkg::ROM_BANK_BITS) == '0);

   assign vrom_cover = cbm_pkg::cover_mask(cbm_pkg::BANK_W'(vrom_cnt_ff) - 16'd1);
   assign vrom_b     = req_bank_num & vrom_cover;
   assign vrom_ok    = (vrom_b < cbm_pkg::BANK_W'(vrom_cnt_ff)) &&
                       ((vrom_b >> cbm_pkg::VROM_BANK_BITS) == '0);

   // slot decode for writes
   logic                              cpu_slot_ok, vid_slot_ok, patt_slot;
   logic [cbm_pkg::SLOT_W-1:0]        cpu_slot_rel;
   logic [cbm_pkg::CPU_IDX_BITS-1:0]  cpu_wr_idx;
   logic [cbm_pkg::VID_IDX_BITS-1:0]  vid_wr_idx;

   assign cpu_slot_ok  = (req_slot >= cbm_pkg::SLOT_W'(cbm_pkg::CPU_FIRST_PG)) &&
                         (req_slot <= cbm_pkg::SLOT_W'(cbm_pkg::CPU_LAST_PG));
   assign cpu_slot_rel = req_slot - cbm_pkg::SLOT_W'(cbm_pkg::CPU_FIRST_PG);
   assign cpu_wr_idx   = cpu_slot_rel[cbm_pkg::CPU_IDX_BITS-1:0];
   assign vid_slot_ok  = req_slot < cbm_pkg::SLOT_W'(cbm_pkg::VID_SLOTS);
   assign patt_slot    = req_slot < cbm_pkg::SLOT_W'(cbm_pkg::PATT_SLOTS);
   assign vid_wr_idx   = req_slot[cbm_pkg::VID_IDX_BITS-1:0];

   // translate decode: CPU page from the top address bits, video slot
   // from the 1K page number
   logic [2:0]                        cpu_page, cpu_page_rel;
   logic                              cpu_page_ok, vid_addr_ok;
   logic [cbm_pkg::CPU_IDX_BITS-1:0]  cpu_rd_idx;
   logic [cbm_pkg::VID_IDX_BITS-1:0]  vid_rd_idx;
   cbm_pkg::vid_entry_type            vid_rd;

   assign cpu_page     = req_address[cbm_pkg::ADDR_W-1:cbm_pkg::CPU_OFS_BITS];
   assign cpu_page_ok  = (cpu_page >= 3'(cbm_pkg::CPU_FIRST_PG)) &&
                         (cpu_page <= 3'(cbm_pkg::CPU_LAST_PG));
   assign cpu_page_rel = cpu_page - 3'(cbm_pkg::CPU_FIRST_PG);
   assign cpu_rd_idx   = cpu_page_rel[cbm_pkg::CPU_IDX_BITS-1:0];
   assign vid_addr_ok  = req_address <= cbm_pkg::VID_ADDR_LAST;
   assign vid_rd_idx   = req_address[cbm_pkg::VID_OFS_BITS +: cbm_pkg::VID_IDX_BITS];
   assign vid_rd       = vid_entry_ff[vid_rd_idx];

   // ---------------------------------------------------------------
   // Per-request decode: table write strobes and the response fields
   // ---------------------------------------------------------------
   logic                   cpu_we, vid_we;
   cbm_pkg::vid_entry_type vid_wdata;

   always_comb begin
      cpu_we         = 1'b0;
      vid_we         = 1'b0;
      vid_wdata.src  = cbm_pkg::SPACE_VROM;
      vid_wdata.bank = vrom_b[cbm_pkg::VROM_BANK_BITS-1:0];
      rsp_acc_in     = 1'b0;
      rsp_space_in   = cbm_pkg::SPACE_PROG;
      rsp_phys_in    = '0;
      case (req_type)
         cbm_pkg::REQ_SET_ROM: begin
            if (cpu_slot_ok && rom_ok) begin
               cpu_we     = 1'b1;
               rsp_acc_in = 1'b1;
            end
         end
         cbm_pkg::REQ_SET_VROM: begin
            if (vid_slot_ok) begin
               rsp_space_in = cbm_pkg::SPACE_VROM;
               if (vrom_ok) begin
                  vid_we     = 1'b1;
                  rsp_acc_in = 1'b1;
               end
            end
         end
         cbm_pkg::REQ_SET_VRAM: begin
            if (patt_slot) begin
               vid_we         = 1'b1;
               vid_wdata.src  = cbm_pkg::SPACE_PATT;
               vid_wdata.bank = cbm_pkg::VROM_BANK_BITS'(req_bank_num &
                                                          cbm_pkg::PATT_PAGE_MASK);
               rsp_space_in   = cbm_pkg::SPACE_PATT;
               rsp_acc_in     = 1'b1;
            end else if (vid_slot_ok) begin
               vid_we         = 1'b1;
               vid_wdata.src  = cbm_pkg::SPACE_NAMT;
               vid_wdata.bank = cbm_pkg::VROM_BANK_BITS'(req_bank_num &
                                                          cbm_pkg::NAMT_PAGE_MASK);
               rsp_space_in   = cbm_pkg::SPACE_NAMT;
               rsp_acc_in     = 1'b1;
            end
         end
         cbm_pkg::REQ_XLAT_CPU: begin
            if (cpu_page_ok) begin
               rsp_acc_in  = 1'b1;
               rsp_phys_in = cbm_pkg::PHYS_W'({cpu_bank_ff[cpu_rd_idx],
                               req_address[cbm_pkg::CPU_OFS_BITS-1:0]});
            end
         end
         cbm_pkg::REQ_XLAT_VID: begin
            if (vid_addr_ok) begin
               rsp_acc_in   = 1'b1;
               rsp_space_in = vid_rd.src;
               rsp_phys_in  = cbm_pkg::PHYS_W'({vid_rd.bank,
                                req_address[cbm_pkg::VID_OFS_BITS-1:0]});
            end
         end
         default: begin
            // unknown request: no change, all-zero response
         end
      endcase
   end

   // response register: loads on a request transfer, empties when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (xfer) begin
         rsp_acc_ff   <= rsp_acc_in;
         rsp_space_ff <= rsp_space_in;
         rsp_phys_ff  <= rsp_phys_in;
      end
   end

   // bank counts; must be written only while idle, which the block does not enforce
   always_ff @(posedge clock) begin
      if (reset) begin
         rom_cnt_ff  <= cbm_pkg::ROM_CNT_RST;
         vrom_cnt_ff <= cbm_pkg::VROM_CNT_RST;
      end else if (csr_we) begin
         case (csr_index)
            cbm_pkg::CSR_ROM_COUNT:  rom_cnt_ff  <= csr_wdata[cbm_pkg::ROM_CNT_W-1:0];
            cbm_pkg::CSR_VROM_COUNT: vrom_cnt_ff <= csr_wdata[cbm_pkg::VROM_CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // slot tables
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cbm_pkg::CPU_SLOTS; i++) begin
            cpu_bank_ff[i] <= '0;
         end
         for (int i = 0; i < cbm_pkg::VID_SLOTS; i++) begin
            vid_entry_ff[i].src  <= cbm_pkg::SPACE_VROM;
            vid_entry_ff[i].bank <= '0;
         end
      end else if (xfer) begin
         if (cpu_we) begin
            cpu_bank_ff[cpu_wr_idx] <= rom_b[cbm_pkg::ROM_BANK_BITS-1:0];
         end
         if (vid_we) begin
            vid_entry_ff[vid_wr_idx] <= vid_wdata;
         end
      end
   end

   // ---------------------------------------------------------------
   // Outputs
   // ---------------------------------------------------------------
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = rsp_acc_ff;
   assign rsp_target_space = rsp_space_ff;
   assign rsp_phys_addr    = rsp_phys_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // request side stalls only behind an untaken response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request stalled without a pending response");

   // every request transfer produces a response next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      xfer |=> rsp_valid)
      else $error("request transfer without response");

   // rejected or unmapped items never carry an address
   a_rej_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_accepted) |-> (rsp_phys_addr == '0))
      else $error("rejected response with nonzero address");

   // a taken response without a new transfer leaves the register empty
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !req_valid) |=> !rsp_valid)
      else $error("response register did not drain");

endmodule

### sim/cartridge_bank_mapper_tb.sv
// ---------------------------------------------------------------------------
// cartridge_bank_mapper_tb
// Self-checking bench for the bank mapper: directed slot writes, translates
// and corner counts, a backpressure stretch, then random traffic over
// several bank-count settings. A local copy of the slot tables predicts every
// response; responses are checked in order against that prediction.
// ---------------------------------------------------------------------------
module cartridge_bank_mapper_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cbm_pkg::*;

   // request kinds the block does not decode
   localparam logic [TYPE_W-1:0] REQ_UNDEF_LO = 3'd5;
   localparam logic [TYPE_W-1:0] REQ_UNDEF_HI = 3'd7;

   localparam int CYCLE_LIMIT   = 400_000;
   localparam int PHASE_ITEMS   = 200;
   localparam int QUIET_ITEMS   = 100;
   localparam int HOLD_CYCLES   = 60;

   typedef struct packed {
      logic [TYPE_W-1:0] kind;
      logic [SLOT_W-1:0] slot;
      logic [BANK_W-1:0] bank;
      logic [ADDR_W-1:0] addr;
   } req_fields_type;

   typedef struct packed {
      logic              accepted;
      logic [1:0]        space;
      logic [PHYS_W-1:0] phys;
   } rsp_fields_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [TYPE_W-1:0]     req_type;
   logic [SLOT_W-1:0]     req_slot;
   logic [BANK_W-1:0]     req_bank_num;
   logic [ADDR_W-1:0]     req_address;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_accepted;
   logic [1:0]            rsp_target_space;
   logic [PHYS_W-1:0]     rsp_phys_addr;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // predicted bank tables and counts
   logic [ROM_CNT_W-1:0]     rom_count;
   logic [VROM_CNT_W-1:0]    vrom_count;
   logic [ROM_BANK_BITS-1:0] prog_bank [CPU_SLOTS];
   vid_entry_type            vid_map   [VID_SLOTS];

   rsp_fields_type pending_rsp[$];    // responses owed by the block, oldest first
   int             error_count = 0;
   int             cycle_count = 0;
   int             hold_left   = 0;   // long receiver hold, counted down by the sink
   bit             src_idle_en = 1'b1;
   bit             sink_idle_en = 1'b1;

   // bank-count settings walked by the random phases, extremes first
   int unsigned rom_picks  [8] = '{0, 511, 2, 1, 256, 300, 3, 128};
   int unsigned vrom_picks [8] = '{0, 2047, 8, 1, 1024, 1025, 9, 100};

   cartridge_bank_mapper DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_slot         (req_slot),
      .req_bank_num     (req_bank_num),
      .req_address      (req_address),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_accepted     (rsp_accepted),
      .rsp_target_space (rsp_target_space),
      .rsp_phys_addr    (rsp_phys_addr),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   // Run limit: any hang (lost response, stuck ready) ends here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("cartridge_bank_mapper_tb: done, errors");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------

   // Smallest all-ones 16-bit value covering (count - 1); count 0 wraps to
   // 0xFFFF, so every bank then fails the range check.
   function automatic logic [BANK_W-1:0] span_mask(input int unsigned count);
      logic [BANK_W-1:0] m;
      logic [BANK_W-1:0] r;
      m = BANK_W'(count - 1);
      r = '0;
      for (int i = 0; i < BANK_W; i++)
         if ((m >> i) != 0) r[i] = 1'b1;
      return r;
   endfunction

   function automatic void clear_tables();
      rom_count  = ROM_CNT_RST;
      vrom_count = VROM_CNT_RST;
      for (int i = 0; i < CPU_SLOTS; i++) prog_bank[i] = '0;
      for (int i = 0; i < VID_SLOTS; i++) vid_map[i] = '{SPACE_VROM, '0};
   endfunction

   // Applies one request to the local tables and returns the response it owes.
   function automatic rsp_fields_type map_request(input req_fields_type r);
      rsp_fields_type o;
      logic [BANK_W-1:0] b;
      int pg;
      int vs;
      o = '0;
      case (r.kind)
         REQ_SET_ROM: begin
            // bad slot leaves every field zero
            if (r.slot >= CPU_FIRST_PG && r.slot <= CPU_LAST_PG) begin
               b = r.bank & span_mask(32'(rom_count));
               // count above slot storage: masked bank may still be too wide
               if (b < rom_count && b < (1 << ROM_BANK_BITS)) begin
                  prog_bank[r.slot - CPU_FIRST_PG] = b[ROM_BANK_BITS-1:0];
                  o.accepted = 1'b1;
               end
            end
         end
         REQ_SET_VROM: begin
            if (r.slot < VID_SLOTS) begin
               o.space = SPACE_VROM;
               b = r.bank & span_mask(32'(vrom_count));
               if (b < vrom_count && b < (1 << VROM_BANK_BITS)) begin
                  vid_map[r.slot] = '{SPACE_VROM, b[VROM_BANK_BITS-1:0]};
                  o.accepted = 1'b1;
               end
            end
         end
         REQ_SET_VRAM: begin
            // RAM pages are never range checked
            if (r.slot < PATT_SLOTS) begin
               vid_map[r.slot] = '{SPACE_PATT, VROM_BANK_BITS'(r.bank & PATT_PAGE_MASK)};
               o.space = SPACE_PATT;
               o.accepted = 1'b1;
            end else if (r.slot < VID_SLOTS) begin
               vid_map[r.slot] = '{SPACE_NAMT, VROM_BANK_BITS'(r.bank & NAMT_PAGE_MASK)};
               o.space = SPACE_NAMT;
               o.accepted = 1'b1;
            end
         end
         REQ_XLAT_CPU: begin
            pg = int'(r.addr >> CPU_OFS_BITS);
            if (pg >= CPU_FIRST_PG && pg <= CPU_LAST_PG) begin
               o.accepted = 1'b1;
               o.space = SPACE_PROG;
               o.phys = PHYS_W'({prog_bank[pg - CPU_FIRST_PG], r.addr[CPU_OFS_BITS-1:0]});
            end
         end
         REQ_XLAT_VID: begin
            if (r.addr <= VID_ADDR_LAST) begin
               vs = int'(r.addr >> VID_OFS_BITS);
               o.accepted = 1'b1;
               o.space = vid_map[vs].src;
               o.phys = PHYS_W'({vid_map[vs].bank, r.addr[VID_OFS_BITS-1:0]});
            end
         end
         default: ;   // undecoded kinds: all zero, no state change
      endcase
      return o;
   endfunction

   // -------------------------------------------------------------------------
   // Response side: random stalls, plus the long hold used for backpressure
   // -------------------------------------------------------------------------
   initial begin : sink
      int burst;
      burst = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (burst > 0) begin
            burst--;
            rsp_ready <= 1'b0;
         end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(0, 10);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Every response transfer is checked against the oldest prediction.
   always @(posedge clock) begin : check_rsp
      rsp_fields_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("response transfer with no request outstanding");
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_accepted !== want.accepted) begin
               $error("accepted: expected %0d, got %0d", want.accepted, rsp_accepted);
               error_count++;
            end
            if (rsp_target_space !== want.space) begin
               $error("target_space: expected %0d, got %0d", want.space, rsp_target_space);
               error_count++;
            end
            if (rsp_phys_addr !== want.phys) begin
               $error("phys_addr: expected 0x%06h, got 0x%06h", want.phys, rsp_phys_addr);
               error_count++;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------

   // Offers one request from a falling edge and returns at the falling edge
   // after its transfer. Valid stays high into the next call unless a gap
   // is drawn there, so it is never dropped and raised in one step.
   task automatic send_item(input logic [TYPE_W-1:0] kind, input logic [SLOT_W-1:0] slot,
                            input logic [BANK_W-1:0] bank, input logic [ADDR_W-1:0] addr);
      req_fields_type r;
      r = {kind, slot, bank, addr};
      if (src_idle_en && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_type     <= kind;
      req_slot     <= slot;
      req_bank_num <= bank;
      req_address  <= addr;
      do @(posedge clock); while (!req_ready);
      pending_rsp.push_back(map_request(r));
      @(negedge clock);
   endtask

   // Sender pause: drop valid and wait for every owed response.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_rsp.size() != 0);
   endtask

   // CSR writes only land on an idle block.
   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_ROM_COUNT) rom_count = data[ROM_CNT_W-1:0];
      else                      vrom_count = data[VROM_CNT_W-1:0];
   endtask

   // Random request, weighted toward legal slots and mapped addresses so the
   // tables get filled and read back; the rest is out-of-range noise.
   function automatic req_fields_type random_request();
      req_fields_type r;
      int sel;
      r.slot = SLOT_W'($urandom_range(0, 15));
      r.bank = BANK_W'($urandom_range(0, 16'hFFFF));
      r.addr = ADDR_W'($urandom_range(0, 16'hFFFF));
      sel = $urandom_range(0, 99);
      if (sel < 22) begin
         r.kind = REQ_SET_ROM;
         if ($urandom_range(0, 9) != 0)
            r.slot = SLOT_W'($urandom_range(CPU_FIRST_PG, CPU_LAST_PG));
         if ($urandom_range(0, 1) == 0) r.bank = BANK_W'($urandom_range(0, 600));
      end else if (sel < 40) begin
         r.kind = REQ_SET_VROM;
         if ($urandom_range(0, 9) != 0) r.slot = SLOT_W'($urandom_range(0, VID_SLOTS - 1));
         if ($urandom_range(0, 1) == 0) r.bank = BANK_W'($urandom_range(0, 2100));
      end else if (sel < 52) begin
         r.kind = REQ_SET_VRAM;
         if ($urandom_range(0, 9) != 0) r.slot = SLOT_W'($urandom_range(0, VID_SLOTS - 1));
      end else if (sel < 74) begin
         r.kind = REQ_XLAT_CPU;
         if ($urandom_range(0, 6) != 0) r.addr = ADDR_W'($urandom_range(16'h6000, 16'hFFFF));
      end else if (sel < 96) begin
         r.kind = REQ_XLAT_VID;
         if ($urandom_range(0, 6) != 0) r.addr = ADDR_W'($urandom_range(0, VID_ADDR_LAST));
      end else begin
         r.kind = TYPE_W'($urandom_range(REQ_UNDEF_LO, REQ_UNDEF_HI));
      end
      return r;
   endfunction

   task automatic send_random(input int count);
      req_fields_type r;
      repeat (count) begin
         r = random_request();
         send_item(r.kind, r.slot, r.bank, r.addr);
      end
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Reset tables: all program pages bank 0, all video slots ROM bank 0.
   task automatic test_reset_defaults();
      send_item(REQ_XLAT_CPU, '0, '0, 16'h6000);
      send_item(REQ_XLAT_CPU, '0, '0, 16'hFFFF);
      send_item(REQ_XLAT_CPU, '0, '0, 16'h5FFF);   // page 2, unmapped
      send_item(REQ_XLAT_VID, '0, '0, 16'h0000);
      send_item(REQ_XLAT_VID, '0, '0, 16'h2FFF);
      send_item(REQ_XLAT_VID, '0, '0, 16'h3000);   // above nametables, unmapped
   endtask

   // Program ROM writes across counts: mask wrap, zero count, too-wide bank.
   task automatic test_rom_banks();
      send_item(REQ_SET_ROM, 4'd3, 16'hFFFF, '0);   // masked to 1 with count 2
      send_item(REQ_SET_ROM, 4'd2, 16'h0001, '0);   // bad slot
      send_item(REQ_SET_ROM, 4'd15, 16'h0001, '0);  // bad slot
      send_item(REQ_XLAT_CPU, '0, '0, 16'h7ABC);
      write_csr(CSR_ROM_COUNT, 11'd0);
      send_item(REQ_SET_ROM, 4'd7, 16'h0000, '0);   // zero count rejects all
      write_csr(CSR_ROM_COUNT, 11'd3);
      send_item(REQ_SET_ROM, 4'd4, 16'h0003, '0);   // masked bank equals count
      write_csr(CSR_ROM_COUNT, {2'b11, 9'd300});    // upper data bits ignored
      send_item(REQ_SET_ROM, 4'd5, 16'd299, '0);    // fits count, not storage
      send_item(REQ_SET_ROM, 4'd7, 16'd255, '0);
      send_item(REQ_XLAT_CPU, '0, '0, 16'hFFFF);
   endtask

   // Video ROM and RAM page writes, then reads of the slot boundaries.
   task automatic test_video_banks();
      send_item(REQ_SET_VROM, 4'd11, 16'hFFFF, '0);  // masked to 7 with count 8
      send_item(REQ_SET_VROM, 4'd12, 16'h0001, '0);  // bad slot
      write_csr(CSR_VROM_COUNT, 11'd2047);
      send_item(REQ_SET_VROM, 4'd0, 16'd1500, '0);   // too wide for a slot
      send_item(REQ_SET_VROM, 4'd1, 16'd1023, '0);
      send_item(REQ_SET_VRAM, 4'd7, 16'hFFFF, '0);   // pattern page
      send_item(REQ_SET_VRAM, 4'd8, 16'hFFFF, '0);   // nametable page
      send_item(REQ_SET_VRAM, 4'd15, 16'h0001, '0);  // bad slot
      send_item(REQ_XLAT_VID, '0, '0, 16'h07FF);
      send_item(REQ_XLAT_VID, '0, '0, 16'h1FFF);
      send_item(REQ_XLAT_VID, '0, '0, 16'h2000);
      send_item(REQ_XLAT_VID, '0, '0, 16'h2FFF);
   endtask

   task automatic test_undefined_kinds();
      for (int k = int'(REQ_UNDEF_LO); k <= int'(REQ_UNDEF_HI); k++)
         send_item(TYPE_W'(k), SLOT_W'($urandom_range(0, 15)),
                   BANK_W'($urandom_range(0, 16'hFFFF)),
                   ADDR_W'($urandom_range(0, 16'hFFFF)));
   endtask

   // Receiver holds off long enough that the response register fills and
   // the request side stalls; afterwards the sender waits for a full drain.
   task automatic test_backpressure();
      src_idle_en = 1'b0;
      hold_left   = HOLD_CYCLES;
      send_random(20);
      wait_drained();
      src_idle_en = 1'b1;
   endtask

   // Random traffic, one count setting per phase; the final phase runs with
   // no idling on either side.
   task automatic test_random_traffic();
      for (int p = 0; p < 8; p++) begin
         write_csr(CSR_ROM_COUNT, {2'($urandom_range(0, 3)), 9'(rom_picks[p])});
         write_csr(CSR_VROM_COUNT, 11'(vrom_picks[p]));
         send_random(PHASE_ITEMS);
      end
      write_csr(CSR_ROM_COUNT, 11'(rom_picks[$urandom_range(0, 7)]));
      write_csr(CSR_VROM_COUNT, 11'(vrom_picks[$urandom_range(0, 7)]));
      src_idle_en  = 1'b0;
      sink_idle_en = 1'b0;
      send_random(QUIET_ITEMS);
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_type     = '0;
      req_slot     = '0;
      req_bank_num = '0;
      req_address  = '0;
      rsp_ready    = 1'b0;
      csr_we       = 1'b0;
      csr_index    = CSR_ROM_COUNT;
      csr_wdata    = '0;
      clear_tables();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_rom_banks();
      test_video_banks();
      test_undefined_kinds();
      test_backpressure();
      test_random_traffic();

      wait_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("cartridge_bank_mapper_tb: done, clean");
      end else begin
         $display("cartridge_bank_mapper_tb: done, errors");
      end
      $finish;
   end

endmodule
